// ----- hdl/kaa_pkg.sv -----
// ----------------------------------------------------------------------------
// kaa_pkg: shared constants for the k-means assignment core
// Item codes, register indexes and field widths.
// ----------------------------------------------------------------------------
package kaa_pkg;

   localparam int DEF_MAX_CLASSES = 16;
   localparam int DEF_MAX_BANDS   = 4;
   localparam int DEF_SAMPLE_BITS = 16;

   localparam int NUM_IN_BANDS = 4;
   localparam int MEAN_W       = 24;
   localparam int SUM_W        = 48;
   localparam int CNT_W        = 32;
   localparam int SMP_W        = 16;
   localparam int DIST_W       = 64;
   localparam int CLS_W        = 4;

   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_PIXEL = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;
   localparam logic [1:0] MODE_SPARE = 2'd3;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   localparam logic [0:0] CSR_CLASS_COUNT = 1'd0;
   localparam logic [0:0] CSR_BAND_COUNT  = 1'd1;

   // request tdata: mode, class_index, sample_0..3, mean_0..3 = 2+4+64+96 = 166 -> 168
   localparam int REQ_W = 168;
   // response tdata: winner_class, new_mean_0..3, class_pixel_count = 4+96+32 -> 136
   localparam int RSP_W = 136;

endpackage

// ----- hdl/kaa_lane.sv -----
// ----------------------------------------------------------------------------
// kaa_lane: one band lane
// Squared distance of one band against one class mean, registered.
// ----------------------------------------------------------------------------
module kaa_lane (
   input  logic                        clock,
   input  logic                        enable,
   input  logic                        active,
   input  logic [kaa_pkg::SMP_W-1:0]   sample,
   input  logic [kaa_pkg::MEAN_W-1:0]  mean,
   output logic [2*kaa_pkg::MEAN_W-1:0] sq_ff
);
   import kaa_pkg::*;

   logic [MEAN_W-1:0]   s_q;
   logic [MEAN_W-1:0]   diff;
   logic [2*MEAN_W-1:0] sq_in;

   always_comb begin
      s_q   = {sample, 8'd0};
      diff  = (s_q >= mean) ? (s_q - mean) : (mean - s_q);
      sq_in = active ? (diff * diff) : '0;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sq_ff <= sq_in;
      end
   end
endmodule

// ----- hdl/kaa_merge.sv -----
// ----------------------------------------------------------------------------
// kaa_merge: merge lane distances and track the nearest class
// Adds the lane squares and keeps the running minimum with its class.
// ----------------------------------------------------------------------------
module kaa_merge #(
   parameter int MAX_BANDS = kaa_pkg::DEF_MAX_BANDS,
   parameter int CIDX_W    = 4
) (
   input  logic                            clock,
   input  logic                            first,
   input  logic                            enable,
   input  logic [CIDX_W-1:0]               cls,
   input  logic [2*kaa_pkg::MEAN_W-1:0]    sq [MAX_BANDS],
   output logic [CIDX_W-1:0]               win_ff
);
   import kaa_pkg::*;

   logic [DIST_W-1:0] best_ff, best_in, dist_sum;
   logic [CIDX_W-1:0] win_in;

   always_comb begin
      dist_sum = '0;
      for (int b = 0; b < MAX_BANDS; b++) dist_sum = dist_sum + DIST_W'(sq[b]);
      best_in = best_ff;
      win_in  = win_ff;
      if (first || dist_sum < best_ff) begin
         best_in = dist_sum;
         win_in  = cls;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         best_ff <= best_in;
         win_ff  <= win_in;
      end
   end
endmodule

// ----- hdl/kaa_divider.sv -----
// ----------------------------------------------------------------------------
// kaa_divider: restoring divider, one quotient bit per cycle
// Divides a 56-bit dividend by a 32-bit count; quotient truncated to 24 bits.
// ----------------------------------------------------------------------------
module kaa_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [kaa_pkg::SUM_W+7:0]   dividend,
   input  logic [kaa_pkg::CNT_W-1:0]   divisor,
   output logic                        busy_ff,
   output logic [kaa_pkg::MEAN_W-1:0]  quot
);
   import kaa_pkg::*;
   localparam int N = SUM_W + 8;

   logic [N-1:0]       q_ff, q_in;
   logic [CNT_W:0]     r_ff, r_in, trial;
   logic [5:0]         n_ff, n_in;
   logic               busy_in;

   always_comb begin
      q_in = q_ff; r_in = r_ff; n_in = n_ff; busy_in = busy_ff;
      trial = {r_ff[CNT_W-1:0], q_ff[N-1]};
      if (start) begin
         q_in = dividend; r_in = '0; n_in = 6'(N); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            r_in = trial - {1'b0, divisor};
            q_in = {q_ff[N-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[N-2:0], 1'b0};
         end
         n_in = n_ff - 6'd1;
         if (n_ff == 6'd1) busy_in = 1'b0;
      end
   end
   assign quot = q_ff[MEAN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) busy_ff <= 1'b0;
      else       busy_ff <= busy_in;
      q_ff <= q_in; r_ff <= r_in; n_ff <= n_in;
   end
endmodule

// ----- hdl/kmeans_assign_accumulate_core.sv -----
// ----------------------------------------------------------------------------
// kmeans_assign_accumulate_core: k-means assignment and accumulation
// Band lanes compare a pixel with one class per cycle; sums and counts update.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  req_    | in        | mode, class, samples, initial means
//  rsp_    | out       | kind, winner class, new means, pixel count
//  csr_    | in        | class_count (0), band_count (1)
//
// A load clears the class's sum-table rows, one a cycle over a shared port.
// A pixel passes one class per cycle through the lanes, then the pipeline
// drains, then the winner's sums and count update.
// A read runs each band through the shared bit-serial divider; a band whose
// count is zero keeps its loaded mean instead.
// Reset is synchronous and clears the counts through valid bits (no sweep).
// The result moves to an output register, so the next item is taken while it
// waits; a second result holds in ST_OUT until the first has gone.
module kmeans_assign_accumulate_core
   import kaa_pkg::*;
#(
   parameter int MAX_CLASSES = DEF_MAX_CLASSES,
   parameter int MAX_BANDS   = DEF_MAX_BANDS,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // mode[1:0], class_index[5:2], sample_0..3[69:6], mean_0..3[165:70], zero pad
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // winner_class[3:0], new_mean_0..3[99:4], class_pixel_count[131:100], pad
   output logic [RSP_W-1:0] rsp_tdata,
   // kind
   output logic             rsp_tuser,
   input  logic             csr_we,
   input  logic [0:0]       csr_index,
   input  logic [4:0]       csr_wdata
);
   localparam int CIDX_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
   localparam int BIDX_W = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
   localparam int ROWS   = MAX_CLASSES * MAX_BANDS;
   localparam int RIDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_LOAD  = 8'b00000010,
      ST_SCAN  = 8'b00000100,
      ST_LAST  = 8'b00001000,
      ST_ACC   = 8'b00010000,
      ST_RDSUM = 8'b00100000,
      ST_DIV   = 8'b01000000,
      ST_OUT   = 8'b10000000
   } state_type;

   state_type state_ff, state_in;

   logic [4:0] class_count_ff;
   logic [2:0] band_count_ff;

   // Means: one row per class, all bands side by side (read by all lanes).
   logic [MAX_BANDS*MEAN_W-1:0] mean_mem [MAX_CLASSES];
   logic [MAX_BANDS*MEAN_W-1:0] mean_rd_ff;
   logic [SUM_W-1:0]  sum_mem [ROWS];
   logic [SUM_W-1:0]  sum_rd_ff;
   logic [CNT_W-1:0]  cnt_ff [MAX_CLASSES];
   logic [MAX_CLASSES-1:0] cvalid_ff;

   logic [1:0]        mode_ff;
   logic [CIDX_W-1:0] cls_ff;
   logic [SMP_W-1:0]  smp_ff [MAX_BANDS];
   logic [CIDX_W-1:0] scan_ff, scan_in, lag_ff;
   logic [BIDX_W-1:0] band_ff, band_in;
   logic [CNT_W-1:0]  cnt_cur;
   logic [MEAN_W-1:0] nm_ff [NUM_IN_BANDS];
   logic [CNT_W-1:0]  ocnt_ff;
   logic [RSP_W-1:0]  rsp_data_ff;
   logic              rsp_kind_ff;
   logic              rsp_valid_ff;
   logic              out_go;

   logic [CIDX_W-1:0] eff_nc_m1;
   logic [2:0]        eff_nb;
   logic [CIDX_W-1:0] win;
   logic [2*MEAN_W-1:0] sq [MAX_BANDS];
   logic              div_busy;
   logic [MEAN_W-1:0] quot;
   logic              div_start;
   logic              lane_en;
   logic              acc_ok;
   logic [CIDX_W-1:0] row_cls;
   logic [RIDX_W-1:0] row_addr;
   logic [RIDX_W-1:0] sum_rd_addr;

   logic       accept;
   logic [1:0] in_mode;
   logic [3:0] in_cls;

   assign in_mode = req_tdata[1:0];
   assign in_cls  = req_tdata[5:2];
   assign accept  = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   // Hand the result over once the output register is free or draining.
   assign out_go  = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);

   // Clamp the registers into range.
   always_comb begin
      if (class_count_ff == 5'd0) eff_nc_m1 = '0;
      else if (32'(class_count_ff) > MAX_CLASSES) eff_nc_m1 = CIDX_W'(MAX_CLASSES - 1);
      else eff_nc_m1 = CIDX_W'(class_count_ff - 5'd1);
      if (band_count_ff == 3'd0) eff_nb = 3'd1;
      else if (32'(band_count_ff) > MAX_BANDS) eff_nb = 3'(MAX_BANDS);
      else eff_nb = band_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         class_count_ff <= 5'd16;
         band_count_ff  <= 3'd4;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CLASS_COUNT: class_count_ff <= csr_wdata;
            CSR_BAND_COUNT:  band_count_ff  <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // Lanes: one per band, fed by the mean row read in the previous cycle.
   assign lane_en = (state_ff == ST_SCAN) || (state_ff == ST_LAST);
   for (genvar b = 0; b < MAX_BANDS; b++) begin : g_lane
      kaa_lane u_lane (
         .clock  (clock),
         .enable (lane_en),
         .active (3'(b) < eff_nb),
         .sample (smp_ff[b]),
         .mean   (mean_rd_ff[b*MEAN_W +: MEAN_W]),
         .sq_ff  (sq[b])
      );
   end

   // Merge the lane squares behind the scan: mean read, then square, each registered.
   logic merge_en, merge_first;
   logic [CIDX_W-1:0] merge_cls;
   logic merge_pend_ff, merge_first_ff, scan_d_ff;
   always_ff @(posedge clock) begin
      scan_d_ff      <= (state_ff == ST_SCAN);
      merge_pend_ff  <= scan_d_ff;
      merge_first_ff <= scan_d_ff && !merge_pend_ff;
      merge_cls      <= lag_ff;
   end
   assign merge_en    = merge_pend_ff;
   assign merge_first = merge_first_ff;

   kaa_merge #(.MAX_BANDS(MAX_BANDS), .CIDX_W(CIDX_W)) u_merge (
      .clock  (clock),
      .first  (merge_first),
      .enable (merge_en),
      .cls    (merge_cls),
      .sq     (sq),
      .win_ff (win)
   );

   assign cnt_cur   = cvalid_ff[row_cls] ? cnt_ff[row_cls] : '0;
   assign acc_ok    = cnt_cur != '1;
   assign row_cls   = (mode_ff == MODE_PIXEL) ? win : cls_ff;
   assign row_addr  = RIDX_W'(32'(row_cls) * MAX_BANDS + 32'(band_ff));
   assign div_start = (state_ff == ST_RDSUM) && (cnt_cur != '0);

   // Prefetch the sum row that the next step needs.
   always_comb begin
      if (state_ff == ST_IDLE)
         sum_rd_addr = RIDX_W'(32'(in_cls) * MAX_BANDS);
      else if (state_ff == ST_ACC || state_ff == ST_DIV)
         sum_rd_addr = RIDX_W'(32'(row_addr) + 1);
      else
         sum_rd_addr = row_addr;
   end

   kaa_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({sum_rd_ff, 8'd0}),
      .divisor  (cnt_cur),
      .busy_ff  (div_busy),
      .quot     (quot)
   );

   // Sequencer.
   logic [1:0] wait_ff;
   always_comb begin
      state_in = state_ff;
      scan_in  = scan_ff;
      band_in  = band_ff;
      unique case (state_ff)
         ST_IDLE: begin
            scan_in = '0; band_in = '0;
            if (accept) begin
               if (in_mode == MODE_LOAD && 32'(in_cls) < MAX_CLASSES) state_in = ST_LOAD;
               else if (in_mode == MODE_PIXEL) state_in = ST_SCAN;
               else if (in_mode == MODE_READ && 32'(in_cls) < MAX_CLASSES)
                  state_in = ST_RDSUM;
            end
         end
         ST_LOAD: begin
            band_in = band_ff + 1'b1;
            if (32'(band_ff) == MAX_BANDS - 1) state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (scan_ff == eff_nc_m1) state_in = ST_LAST;
            else scan_in = scan_ff + 1'b1;
         end
         ST_LAST: if (wait_ff == 2'd3) state_in = ST_ACC;
         ST_ACC: begin
            band_in = band_ff + 1'b1;
            if (32'(band_ff) == MAX_BANDS - 1) state_in = ST_OUT;
         end
         ST_RDSUM: state_in = ST_DIV;
         ST_DIV: if (!div_busy) begin
            band_in = band_ff + 1'b1;
            state_in = (32'(band_ff) == MAX_BANDS - 1) ? ST_OUT : ST_RDSUM;
         end
         ST_OUT: if (out_go) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wait_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         cvalid_ff <= '0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= (state_ff == ST_LAST) ? wait_ff + 2'd1 : 2'd0;
         if (out_go) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         if (state_ff == ST_LOAD && band_ff == '0) cvalid_ff[cls_ff] <= 1'b1;
      end
      scan_ff <= scan_in;
      band_ff <= band_in;
      lag_ff  <= scan_ff;
      // Hold the item.
      if (accept) begin
         mode_ff <= in_mode;
         cls_ff  <= CIDX_W'(in_cls);
         for (int b = 0; b < MAX_BANDS; b++) begin
            if (b < NUM_IN_BANDS)
               smp_ff[b] <= SMP_W'(req_tdata[6 + 16*b +: 16] & ((17'd1 << SAMPLE_BITS) - 17'd1));
            else
               smp_ff[b] <= '0;
         end
      end
      // Mean memory: read one class a cycle while scanning.
      mean_rd_ff <= mean_mem[(state_ff == ST_SCAN) ? scan_ff : cls_ff];
      // Sum memory: one row a cycle.
      if (state_ff == ST_LOAD) sum_mem[row_addr] <= '0;
      else if (state_ff == ST_ACC && acc_ok && 3'(band_ff) < eff_nb)
         sum_mem[row_addr] <= sum_rd_ff + SUM_W'(smp_ff[band_ff]);
      sum_rd_ff <= sum_mem[sum_rd_addr];
      // Advance the count after the last band so every band sees the old count.
      if (state_ff == ST_LOAD && band_ff == '0) cnt_ff[cls_ff] <= '0;
      if (state_ff == ST_ACC && 32'(band_ff) == MAX_BANDS - 1 && acc_ok)
         cnt_ff[win] <= cnt_cur + 1'b1;
      // Result.
      if (state_ff == ST_DIV && !div_busy) begin
         if (cnt_cur == '0) nm_ff[band_ff] <= mean_rd_ff[band_ff*MEAN_W +: MEAN_W];
         else nm_ff[band_ff] <= quot;
      end
      if (state_ff == ST_IDLE)
         for (int b = 0; b < NUM_IN_BANDS; b++) nm_ff[b] <= '0;
      if (state_ff == ST_ACC && band_ff == '0) ocnt_ff <= acc_ok ? cnt_cur + 1'b1 : cnt_cur;
      if (state_ff == ST_DIV) ocnt_ff <= cnt_cur;
      if (out_go) begin
         rsp_kind_ff <= (mode_ff == MODE_PIXEL) ? KIND_PIXEL : KIND_READ;
         rsp_data_ff <= {4'd0, ocnt_ff, nm_ff[3], nm_ff[2], nm_ff[1], nm_ff[0],
                         4'((mode_ff == MODE_PIXEL) ? win : cls_ff)};
      end
   end

   always_ff @(posedge clock) begin
      if (accept && in_mode == MODE_LOAD && 32'(in_cls) < MAX_CLASSES) begin
         for (int b = 0; b < MAX_BANDS; b++)
            mean_mem[CIDX_W'(in_cls)][b*MEAN_W +: MEAN_W] <=
               (b < NUM_IN_BANDS) ? req_tdata[70 + 24*b +: 24] : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A waiting result holds steady until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");
   // A result appears only after the sequencer's output step.
   a_out_from_seq: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == ST_OUT) else $error("stray result");
   // The divider is never busy outside a readout.
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> (state_ff == ST_DIV)) else $error("divider busy out of turn");

endmodule

// ----- tb/kaa_checker.sv -----
// ----------------------------------------------------------------------------
// kaa_checker: cluster assignment predictor and result checker
// Watches the request, response and register ports, keeps its own copy of
// the class tables, predicts each response and compares it field by field.
// ----------------------------------------------------------------------------
module kaa_checker
   import kaa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,
   input  logic             rsp_tuser,
   input  logic             csr_we,
   input  logic [0:0]       csr_index,
   input  logic [4:0]       csr_wdata,
   output int               fail_count,
   output int               pending_count,
   output int               rsp_seen
);

   typedef struct packed {
      logic              kind;
      logic [CLS_W-1:0]  cls;
      logic [MEAN_W-1:0] m3, m2, m1, m0;
      logic [CNT_W-1:0]  cnt;
   } cluster_result_type;

   logic [4:0]        n_classes;
   logic [2:0]        n_bands;
   logic [MEAN_W-1:0] centre [16][4];
   logic [SUM_W-1:0]  band_sum [16][4];
   logic [CNT_W-1:0]  members [16];
   cluster_result_type awaited [$];

   assign pending_count = awaited.size();

   function automatic logic [MEAN_W-1:0] mean_of(logic [REQ_W-1:0] d, int b);
      return d[70 + 24*b +: 24];
   endfunction

   function automatic logic [SMP_W-1:0] sample_of(logic [REQ_W-1:0] d, int b);
      return d[6 + 16*b +: 16];
   endfunction

   // apply one request item to the shadow tables, queue what it should give
   task automatic absorb_item(input logic [REQ_W-1:0] d);
      logic [1:0]      mode;
      logic [3:0]      cls;
      int              nc, nb, win;
      logic [63:0]     best, dist_acc, s, m, df;
      cluster_result_type r;
      mode = d[1:0];
      cls  = d[5:2];
      nc = (n_classes < 1) ? 1 : (n_classes > 16) ? 16 : n_classes;
      nb = (n_bands < 1) ? 1 : (n_bands > 4) ? 4 : n_bands;
      r = '0;
      case (mode)
         MODE_LOAD: begin
            for (int b = 0; b < 4; b++) begin
               centre[cls][b]   = mean_of(d, b);
               band_sum[cls][b] = '0;
            end
            members[cls] = '0;
         end
         MODE_PIXEL: begin
            win = 0;
            best = '0;
            for (int k = 0; k < nc; k++) begin
               dist_acc = '0;
               for (int b = 0; b < nb; b++) begin
                  s = {40'd0, sample_of(d, b), 8'd0};
                  m = {40'd0, centre[k][b]};
                  df = (s >= m) ? s - m : m - s;
                  dist_acc += df * df;
               end
               if (k == 0 || dist_acc < best) begin
                  best = dist_acc;
                  win  = k;
               end
            end
            if (members[win] != '1) begin
               members[win]++;
               for (int b = 0; b < nb; b++)
                  band_sum[win][b] += sample_of(d, b);
            end
            r.kind = KIND_PIXEL;
            r.cls  = CLS_W'(win);
            r.cnt  = members[win];
            awaited = {awaited, r};
         end
         MODE_READ: begin
            logic [MEAN_W-1:0] nm [4];
            for (int b = 0; b < 4; b++) begin
               if (members[cls] != 0)
                  nm[b] = MEAN_W'(64'({band_sum[cls][b], 8'd0}) / members[cls]);
               else
                  nm[b] = centre[cls][b];
            end
            r.kind = KIND_READ;
            r.cls  = cls;
            r.m0 = nm[0]; r.m1 = nm[1]; r.m2 = nm[2]; r.m3 = nm[3];
            r.cnt  = members[cls];
            awaited = {awaited, r};
         end
         default: ;
      endcase
   endtask

   task automatic compare(input string fname, input longint unsigned e,
                          input longint unsigned a);
      if (e != a) begin
         $error("%s mismatch: expected %0h, actual %0h", fname, e, a);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      cluster_result_type e;
      if (reset) begin
         n_classes = 16;
         n_bands   = 4;
         fail_count = 0;
         rsp_seen   <= 0;
         awaited.delete();
         foreach (members[k]) begin
            members[k] = '0;
            for (int b = 0; b < 4; b++) begin
               band_sum[k][b] = '0;
               centre[k][b]   = '0;
            end
         end
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_CLASS_COUNT) n_classes = csr_wdata;
            else n_bands = csr_wdata[2:0];
         end
         if (req_tvalid && req_tready) absorb_item(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen <= rsp_seen + 1;
            if (awaited.size() == 0) begin
               $error("unexpected result item: kind %0d class %0d",
                      rsp_tuser, rsp_tdata[3:0]);
               fail_count++;
            end else begin
               e = awaited.pop_front();
               compare("kind", e.kind, rsp_tuser);
               compare("winner_class", e.cls, rsp_tdata[3:0]);
               compare("new_mean_0", e.m0, rsp_tdata[4 +: 24]);
               compare("new_mean_1", e.m1, rsp_tdata[28 +: 24]);
               compare("new_mean_2", e.m2, rsp_tdata[52 +: 24]);
               compare("new_mean_3", e.m3, rsp_tdata[76 +: 24]);
               compare("class_pixel_count", e.cnt, rsp_tdata[100 +: 32]);
            end
         end
      end
   end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: k-means assignment core testbench
// Loads class means, streams directed then random pixels and readouts under
// several class and band settings with random idling on both channels; the
// checker predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb;
   import kaa_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tuser;
   logic             csr_we = 1'b0;
   logic [0:0]       csr_index = CSR_CLASS_COUNT;
   logic [4:0]       csr_wdata = '0;

   int fail_count, pending_count, rsp_seen;
   int idle_run;
   // receiver behaviour: 0 random bursts, 1 long hold-off, 2 always ready
   int sink_mode = 0;
   bit loaded [16];

   always #10 clock = ~clock;

   kmeans_assign_accumulate_core u_top (.*);

   kaa_checker u_chk (.*);

   // watchdog: count cycles in which nothing moves
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_run <= 0;
      else
         idle_run <= idle_run + 1;
      if (idle_run >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // result side: random stall bursts, one long hold-off, none at the end
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (sink_mode == 1) begin
         rsp_tready <= 1'b0;
         repeat (400) @(posedge clock);
         sink_mode = 0;
      end else if (sink_mode == 0 && $urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         repeat ($urandom_range(1, 3) - 1) @(posedge clock);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic write_reg(input logic [0:0] idx, input logic [4:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // hold until every expected result is back and the core has settled
   task automatic drain();
      while (pending_count != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   // offer one item; random gap bursts unless quiet is set
   task automatic send(input logic [REQ_W-1:0] d, input bit quiet);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [REQ_W-1:0] pack_req(
         input logic [1:0] mode, input logic [3:0] cls,
         input logic [15:0] s0, s1, s2, s3,
         input logic [23:0] m0, m1, m2, m3);
      return {2'b00, m3, m2, m1, m0, s3, s2, s1, s0, cls, mode};
   endfunction

   function automatic logic [15:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [23:0] rand_mean();
      case ($urandom_range(0, 5))
         0: return 24'h000000;
         1: return 24'hFFFFFF;
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [REQ_W-1:0] rand_pixel();
      return pack_req(MODE_PIXEL, 4'($urandom), rand_sample(), rand_sample(),
                      rand_sample(), rand_sample(), 24'($urandom), 24'($urandom),
                      24'($urandom), 24'($urandom));
   endfunction

   // spare mode is ignored; loads of any class, reads only of classes already loaded
   task automatic random_item(input bit quiet);
      int pick;
      logic [3:0] c;
      pick = $urandom_range(0, 99);
      c = 4'($urandom_range(0, 15));
      if (pick < 8) begin
         send(pack_req(MODE_LOAD, c, 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), rand_mean(), rand_mean(), rand_mean(),
                       rand_mean()), quiet);
         loaded[c] = 1;
      end else if (pick < 20 && loaded[c]) begin
         send(pack_req(MODE_READ, c, 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                       24'($urandom)), quiet);
      end else if (pick < 22) begin
         send(pack_req(MODE_SPARE, c, 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                       24'($urandom)), quiet);
      end else begin
         send(rand_pixel(), quiet);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // load every class so that no pixel ever meets an unwritten mean
      for (int k = 0; k < 16; k++) begin
         send(pack_req(MODE_LOAD, 4'(k), 16'h0, 16'h0, 16'h0, 16'h0,
                       24'(24'h001000 * k), 24'(24'h002000 * k), 24'(24'h000800 * k),
                       (k == 15) ? 24'hFFFFFF : 24'h000000), 1'b0);
         loaded[k] = 1;
      end
      // directed: extreme samples, readouts, ignored mode
      send(pack_req(MODE_PIXEL, '0, 16'h0, 16'h0, 16'h0, 16'h0,
                    '0, '0, '0, '0), 1'b0);
      send(pack_req(MODE_PIXEL, '0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    '0, '0, '0, '0), 1'b0);
      send(pack_req(MODE_PIXEL, '0, 16'h0008, 16'h0, 16'h0, 16'h0,
                    '0, '0, '0, '0), 1'b0);
      send(pack_req(MODE_READ, 4'd0, '0, '0, '0, '0, '0, '0, '0, '0), 1'b0);
      send(pack_req(MODE_READ, 4'd15, '0, '0, '0, '0, '0, '0, '0, '0), 1'b0);
      send(pack_req(MODE_READ, 4'd7, '0, '0, '0, '0, '0, '0, '0, '0), 1'b0);
      send(pack_req(MODE_SPARE, 4'd4, 16'hFFFF, '0, '0, '0, 24'hFFFFFF, '0, '0, '0),
           1'b0);
      send(pack_req(MODE_LOAD, 4'd3, '0, '0, '0, '0, 24'hFFFFFF, 24'hFFFFFF,
                    24'hFFFFFF, 24'hFFFFFF), 1'b0);
      send(pack_req(MODE_READ, 4'd3, '0, '0, '0, '0, '0, '0, '0, '0), 1'b0);
      stop_sending();
      drain();

      // register settings: extremes, out-of-range values and a middle pair
      begin
         logic [4:0] cc [6] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd5, 5'd16};
         logic [4:0] bc [6] = '{5'd1, 5'd4, 5'd0, 5'd7, 5'd2, 5'd4};
         for (int ph = 0; ph < 6; ph++) begin
            write_reg(CSR_CLASS_COUNT, cc[ph]);
            write_reg(CSR_BAND_COUNT, bc[ph]);
            if (ph == 1) sink_mode = 1;
            for (int i = 0; i < 230; i++) random_item(1'b0);
            stop_sending();
            drain();
         end
         // tail with no idling on either side
         sink_mode = 2;
         for (int i = 0; i < 120; i++) random_item(1'b1);
         stop_sending();
      end

      while (pending_count != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/kaa_pkg.sv
hdl/kaa_lane.sv
hdl/kaa_merge.sv
hdl/kaa_divider.sv
hdl/kmeans_assign_accumulate_core.sv
tb/kaa_checker.sv
tb/tb.sv
